[hdl/mlpi_pkg.sv]
// Shared types and constants for the two-layer perceptron policy block.
package mlpi_pkg;

    localparam int WORD_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int INDEX_W   = 11;
    localparam int SEL_W     = 3;
    localparam int IN_DATA_W = 80;
    localparam int OUT_DATA_W = 64;

    localparam logic [SEL_W-1:0] ACC_HIDDEN = 3'd4;
    localparam logic signed [WORD_W-1:0] BIAS_SCALE = 16'sd256;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    localparam logic CFG_SPEED_LIMIT = 1'b0;
    localparam logic CFG_TURN_LIMIT  = 1'b1;

    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET = 15'd10240;
    localparam logic [LIMIT_W-1:0] TURN_LIMIT_RESET  = 15'd804;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OPND_BIAS,
        OPND_F0,
        OPND_F1,
        OPND_F2,
        OPND_HID
    } t_opnd;

    typedef struct packed {
        logic             vld;
        logic             clr;
        logic [SEL_W-1:0] acc;
        t_opnd            opnd;
    } t_mac_op;

    function automatic logic signed [WORD_W-1:0] clip_sym(
        input logic signed [WORD_W-1:0] v,
        input logic [LIMIT_W-1:0]       lim
    );
        logic signed [WORD_W:0] vx;
        logic signed [WORD_W:0] hi;
        logic signed [WORD_W:0] lo;
        vx = {v[WORD_W-1], v};
        hi = $signed({2'b00, lim});
        lo = -hi;
        if (vx > hi) begin
            clip_sym = hi[WORD_W-1:0];
        end else if (vx < lo) begin
            clip_sym = lo[WORD_W-1:0];
        end else begin
            clip_sym = v;
        end
    endfunction

endpackage

[hdl/mlpi_wmem.sv]
// Weight store: one write port, one registered read port.
module mlpi_wmem
    import mlpi_pkg::*;
#(
    parameter int DEPTH = 1604,
    parameter int AW    = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic signed [WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic signed [WORD_W-1:0] o_rdata
);

    logic signed [WORD_W-1:0] r_mem [0:DEPTH-1];
    logic signed [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mlpi_mac.sv]
// Shared multiply-accumulate unit with five accumulators and Q8.8 rounding.
module mlpi_mac
    import mlpi_pkg::*;
#(
    parameter int ACC_W = 42
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_op                  i_op,
    input  logic signed [WORD_W-1:0] i_wgt,
    input  logic signed [WORD_W-1:0] i_opnd,
    input  logic [SEL_W-1:0]         i_rsel,
    output logic signed [WORD_W-1:0] o_rnd
);

    localparam int NUM_ACC = 5;

    logic                         r_vld;
    logic                         r_clr;
    logic [SEL_W-1:0]             r_sel;
    logic signed [2*WORD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]      r_acc [0:NUM_ACC-1];

    logic signed [ACC_W-1:0]      acc_base;
    logic signed [ACC_W:0]        rnd_sum;
    logic signed [ACC_W:0]        rnd_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_op.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clr  <= i_op.clr;
        r_sel  <= i_op.acc;
        r_prod <= i_wgt * i_opnd;
    end

    assign acc_base = r_clr ? '0 : r_acc[r_sel];

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_acc[r_sel] <= acc_base + ACC_W'(r_prod);
        end
    end

    always_comb begin
        rnd_sum = {r_acc[i_rsel][ACC_W-1], r_acc[i_rsel]} + (ACC_W+1)'(128);
        rnd_q   = rnd_sum >>> 8;
        if (rnd_q > $signed((ACC_W+1)'(32767))) begin
            o_rnd = 16'sh7FFF;
        end else if (rnd_q < -$signed((ACC_W+1)'(32768))) begin
            o_rnd = 16'sh8000;
        end else begin
            o_rnd = rnd_q[WORD_W-1:0];
        end
    end

endmodule

[hdl/mlp_policy_inference.sv]
// Top level: sequencer, limits and output register of the perceptron policy block.
//
//  channel   | dir | handshake                    | payload
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | tuser mode, tdata weight or features
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata four Q8.8 results
//  cfg       | in  | i_cfg_we                     | i_cfg_addr, i_cfg_wdata
//
//  An evaluation is paced by one multiply per cycle on the shared MAC and the single
//  read port of the weight store. Ready is low while an evaluation runs.
//  The result waits in the output register; a new item is taken meanwhile.
//  Reset clears control state and the limits; the weight store is undefined until written.
module mlp_policy_inference
    import mlpi_pkg::*;
#(
    parameter int HIDDEN_UNITS = 200
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // weight_index, weight_value, forward_offset, lateral_offset, heading, zero fill
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    // mode
    input  logic                    s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // speed_command, turn_command, speed_log_spread, turn_log_spread
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                    i_cfg_we,
    input  logic                    i_cfg_addr,
    input  logic [LIMIT_W-1:0]      i_cfg_wdata
);

    localparam int DEPTH = 8 * HIDDEN_UNITS + 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int UW    = $clog2(HIDDEN_UNITS + 1);
    localparam int ACC_W = 34 + $clog2(HIDDEN_UNITS + 1);

    localparam logic [AW-1:0] BASE_W1_1 = AW'(HIDDEN_UNITS);
    localparam logic [AW-1:0] BASE_W1_2 = AW'(2 * HIDDEN_UNITS);
    localparam logic [AW-1:0] BASE_B1   = AW'(3 * HIDDEN_UNITS);
    localparam logic [AW-1:0] BASE_W2   = AW'(4 * HIDDEN_UNITS);
    localparam logic [AW-1:0] BASE_B2   = AW'(8 * HIDDEN_UNITS);
    localparam logic [UW-1:0] LAST_UNIT = UW'(HIDDEN_UNITS);

    t_state r_state, n_state;

    logic [2:0]               r_slot, n_slot;
    logic [UW-1:0]            r_unit, n_unit;
    logic [AW-1:0]            r_oaddr;
    logic signed [WORD_W-1:0] r_feat [0:2];
    logic signed [WORD_W-1:0] r_hv;
    t_mac_op                  r_op_d;
    t_mac_op                  op;
    logic signed [WORD_W-1:0] r_res [0:3];
    logic [LIMIT_W-1:0]       r_speed_lim;
    logic [LIMIT_W-1:0]       r_turn_lim;
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;

    logic                     in_acc;
    logic [INDEX_W-1:0]       in_index;
    logic signed [WORD_W-1:0] in_value;
    logic                     mem_we;
    logic [AW-1:0]            raddr;
    logic signed [WORD_W-1:0] rdata;
    logic signed [WORD_W-1:0] opnd;
    logic [SEL_W-1:0]         rsel;
    logic signed [WORD_W-1:0] rnd;
    logic signed [WORD_W-1:0] res_val;
    logic                     out_free;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_index = s_axis_tdata[10:0];
    assign in_value = s_axis_tdata[26:11];
    assign mem_we   = in_acc && (s_axis_tuser == MODE_WRITE)
                      && (32'(in_index) < DEPTH);
    assign out_free = !r_out_valid || m_axis_tready;

    mlpi_wmem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_wmem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(AW'(in_index)),
        .i_wdata(in_value),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_comb begin
        case (r_op_d.opnd)
            OPND_BIAS: opnd = BIAS_SCALE;
            OPND_F0:   opnd = r_feat[0];
            OPND_F1:   opnd = r_feat[1];
            OPND_F2:   opnd = r_feat[2];
            OPND_HID:  opnd = r_hv;
            default:   opnd = '0;
        endcase
    end

    mlpi_mac #(
        .ACC_W(ACC_W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_op   (r_op_d),
        .i_wgt  (rdata),
        .i_opnd (opnd),
        .i_rsel (rsel),
        .o_rnd  (rnd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            r_unit  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_unit  <= n_unit;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_slot        = r_slot;
        n_unit        = r_unit;
        s_axis_tready = 1'b0;
        op            = '{vld: 1'b0, clr: 1'b0, acc: ACC_HIDDEN, opnd: OPND_BIAS};
        raddr         = '0;
        rsel          = ACC_HIDDEN;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                n_slot        = '0;
                n_unit        = '0;
                if (in_acc && s_axis_tuser == MODE_EVAL) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                op    = '{vld: 1'b1, clr: 1'b1, acc: {1'b0, r_slot[1:0]}, opnd: OPND_BIAS};
                raddr = BASE_B2 + AW'(r_slot[1:0]);
                n_slot = r_slot + 3'd1;
                if (r_slot == 3'd3) begin
                    n_slot  = '0;
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (!r_slot[2]) begin
                    op.vld = (r_unit != LAST_UNIT);
                    op.acc = ACC_HIDDEN;
                    case (r_slot[1:0])
                        2'd0: begin
                            op.clr  = 1'b1;
                            op.opnd = OPND_BIAS;
                            raddr   = BASE_B1 + AW'(r_unit);
                        end
                        2'd1: begin
                            op.opnd = OPND_F0;
                            raddr   = AW'(r_unit);
                        end
                        2'd2: begin
                            op.opnd = OPND_F1;
                            raddr   = BASE_W1_1 + AW'(r_unit);
                        end
                        default: begin
                            op.opnd = OPND_F2;
                            raddr   = BASE_W1_2 + AW'(r_unit);
                        end
                    endcase
                end else begin
                    op.vld  = (r_unit != '0);
                    op.acc  = {1'b0, r_slot[1:0]};
                    op.opnd = OPND_HID;
                    raddr   = r_oaddr + AW'(r_slot[1:0]);
                end
                n_slot = r_slot + 3'd1;
                if (r_slot == 3'd7) begin
                    if (r_unit == LAST_UNIT) begin
                        n_slot  = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_unit = r_unit + UW'(1);
                    end
                end
            end
            ST_DRAIN: begin
                n_slot = r_slot + 3'd1;
                if (r_slot == 3'd1) begin
                    n_slot  = '0;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                rsel   = {1'b0, r_slot[1:0]};
                n_slot = r_slot + 3'd1;
                if (r_slot == 3'd3) begin
                    n_slot  = '0;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_d <= '{vld: 1'b0, clr: 1'b0, acc: ACC_HIDDEN, opnd: OPND_BIAS};
        end else begin
            r_op_d <= op;
        end
    end

    always_comb begin
        case (r_slot[1:0])
            2'd0:    res_val = clip_sym(rnd, r_speed_lim);
            2'd1:    res_val = clip_sym(rnd, r_turn_lim);
            default: res_val = rnd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && s_axis_tuser == MODE_EVAL) begin
            r_feat[0] <= s_axis_tdata[42:27];
            r_feat[1] <= s_axis_tdata[58:43];
            r_feat[2] <= s_axis_tdata[74:59];
        end
        if (r_state == ST_INIT) begin
            r_oaddr <= BASE_W2;
        end else if (r_state == ST_RUN && r_slot == 3'd7 && r_unit != '0) begin
            r_oaddr <= r_oaddr + AW'(4);
        end
        if (r_state == ST_RUN && r_slot == 3'd0) begin
            r_hv <= rnd[WORD_W-1] ? '0 : rnd;
        end
        if (r_state == ST_FINISH) begin
            r_res[r_slot[1:0]] <= res_val;
        end
        if (r_state == ST_OUT && out_free) begin
            r_out_data <= {r_res[3], r_res[2], r_res[1], r_res[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_lim <= SPEED_LIMIT_RESET;
            r_turn_lim  <= TURN_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_SPEED_LIMIT: r_speed_lim <= i_cfg_wdata;
                CFG_TURN_LIMIT:  r_turn_lim  <= i_cfg_wdata;
                default:         r_speed_lim <= r_speed_lim;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[tb/tb_mlp_policy_inference.sv]
// Self-checking testbench for mlp_policy_inference: directed table, then random weight/eval mix.
module tb_mlp_policy_inference;
    timeunit 1ns;
    timeprecision 1ps;
    import mlpi_pkg::*;

    localparam int UNITS          = 200;
    localparam int DEPTH          = 8 * UNITS + 4;
    localparam int B1_BASE        = 3 * UNITS;
    localparam int W2_BASE        = 4 * UNITS;
    localparam int B2_BASE        = 8 * UNITS;
    localparam int EVAL_CYCLES    = 8 * (UNITS + 1) + 14;
    localparam int SETTLE_CYCLES  = EVAL_CYCLES + 16;
    localparam int WATCHDOG_LIMIT = 4 * (2 * EVAL_CYCLES + 32);
    localparam int PHASE_ITEMS    = 88;
    localparam int MAX_REPORTS    = 10;
    localparam int PAD_W          = IN_DATA_W - 4 * WORD_W - INDEX_W;

    typedef logic signed [WORD_W-1:0] q88_t;

    typedef struct packed {
        logic [PAD_W-1:0]   pad;
        q88_t               heading;
        q88_t               lateral;
        q88_t               forward;
        q88_t               wvalue;
        logic [INDEX_W-1:0] windex;
    } item_data_t;

    typedef struct packed {
        q88_t turn_spread;
        q88_t speed_spread;
        q88_t turn;
        q88_t speed;
    } policy_out_t;

    typedef struct packed {
        logic        mode;
        item_data_t  data;
        logic        typed;
        policy_out_t want;
    } stim_row_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = MODE_WRITE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic                  i_cfg_addr    = CFG_SPEED_LIMIT;
    logic [LIMIT_W-1:0]    i_cfg_wdata   = '0;

    q88_t               weights [DEPTH];
    logic [LIMIT_W-1:0] speed_lim = SPEED_LIMIT_RESET;
    logic [LIMIT_W-1:0] turn_lim  = TURN_LIMIT_RESET;
    policy_out_t        pending [$];
    stim_row_t          directed [$];

    int failures     = 0;
    int results_seen = 0;
    int evals        = 0;
    int writes       = 0;
    int dropped      = 0;
    int stall_left   = 0;
    int stall_draw   = 0;
    int idle_cycles  = 0;
    bit src_steady   = 1'b0;
    bit sink_steady  = 1'b0;

    mlp_policy_inference #(
        .HIDDEN_UNITS(UNITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic q88_t round_q88(longint s);
        longint q;
        q = (s + 128) >>> 8;
        if (q > 32767) q = 32767;
        else if (q < -32768) q = -32768;
        return q[WORD_W-1:0];
    endfunction

    function automatic q88_t clamp_sym(q88_t v, logic [LIMIT_W-1:0] lim);
        int l;
        l = int'(lim);
        if (int'(v) > l) return q88_t'(l);
        if (int'(v) < -l) return q88_t'(-l);
        return v;
    endfunction

    function automatic policy_out_t policy_eval(q88_t f0, q88_t f1, q88_t f2);
        longint      acc [4];
        longint      hsum;
        q88_t        hid;
        q88_t        feat [3];
        policy_out_t r;
        feat[0] = f0;
        feat[1] = f1;
        feat[2] = f2;
        for (int o = 0; o < 4; o++) acc[o] = longint'(weights[B2_BASE + o]) * 256;
        for (int h = 0; h < UNITS; h++) begin
            hsum = longint'(weights[B1_BASE + h]) * 256;
            for (int i = 0; i < 3; i++) begin
                hsum += longint'(weights[i * UNITS + h]) * longint'(feat[i]);
            end
            hid = round_q88(hsum);
            if (hid < 0) hid = '0;
            for (int o = 0; o < 4; o++) begin
                acc[o] += longint'(weights[W2_BASE + 4 * h + o]) * longint'(hid);
            end
        end
        r.speed        = clamp_sym(round_q88(acc[0]), speed_lim);
        r.turn         = clamp_sym(round_q88(acc[1]), turn_lim);
        r.speed_spread = round_q88(acc[2]);
        r.turn_spread  = round_q88(acc[3]);
        return r;
    endfunction

    function automatic policy_out_t outs(int sp, int tu, int ss, int ts);
        policy_out_t r;
        r.speed        = q88_t'(sp);
        r.turn         = q88_t'(tu);
        r.speed_spread = q88_t'(ss);
        r.turn_spread  = q88_t'(ts);
        return r;
    endfunction

    function automatic q88_t rand_weight(bit wide);
        if (wide) return q88_t'($urandom);
        return q88_t'(int'($urandom_range(0, 192)) - 96);
    endfunction

    function automatic q88_t rand_feature();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return q88_t'(int'($urandom_range(0, 2048)) - 1024);
        if (pick < 8) return q88_t'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic item_data_t rand_data();
        item_data_t d;
        d.pad     = '0;
        d.windex  = INDEX_W'($urandom_range(0, DEPTH - 1));
        d.wvalue  = rand_weight($urandom_range(0, 4) == 0);
        d.forward = rand_feature();
        d.lateral = rand_feature();
        d.heading = rand_feature();
        return d;
    endfunction

    task automatic compare_field(string name, q88_t want, q88_t got);
        if (want !== got) begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t %s: expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    task automatic check_result(policy_out_t got);
        policy_out_t want;
        results_seen++;
        if (pending.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t result with nothing pending: %h", $realtime, got);
            return;
        end
        want = pending.pop_front();
        compare_field("speed_command", want.speed, got.speed);
        compare_field("turn_command", want.turn, got.turn);
        compare_field("speed_log_spread", want.speed_spread, got.speed_spread);
        compare_field("turn_log_spread", want.turn_spread, got.turn_spread);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            check_result(policy_out_t'(m_axis_tdata));
            if (results_seen % 8 == 0) sink_steady = ($urandom_range(0, 2) == 0);
            stall_draw = sink_steady ? 0 : $urandom_range(0, 8);
            stall_left    <= stall_draw;
            m_axis_tready <= (stall_draw == 0);
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no handshake for %0d cycles, %0d results pending",
                     $realtime, idle_cycles, pending.size());
            $display("mlp_policy_inference regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(logic mode, item_data_t d, logic typed, policy_out_t want);
        int gap;
        gap = src_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        if (mode == MODE_EVAL) begin
            pending.push_back(typed ? want : policy_eval(d.forward, d.lateral, d.heading));
            evals++;
        end else if (d.windex < DEPTH) begin
            weights[d.windex] = d.wvalue;
            writes++;
        end else begin
            dropped++;
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_limits(logic [LIMIT_W-1:0] sp, logic [LIMIT_W-1:0] tu);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_SPEED_LIMIT;
        i_cfg_wdata <= sp;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_TURN_LIMIT;
        i_cfg_wdata <= tu;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        speed_lim = sp;
        turn_lim  = tu;
    endtask

    task automatic load_weights(bit zero);
        item_data_t d;
        src_steady = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < DEPTH; k++) begin
            d        = rand_data();
            d.windex = INDEX_W'(k);
            d.wvalue = zero ? q88_t'(0) : rand_weight(1'b0);
            send_item(MODE_WRITE, d, 1'b0, '0);
        end
    endtask

    task automatic add_row(logic mode, int idx, int val, int f0, int f1, int f2,
                           logic typed, policy_out_t want);
        stim_row_t r;
        r.mode         = mode;
        r.data.pad     = '0;
        r.data.windex  = INDEX_W'(idx);
        r.data.wvalue  = q88_t'(val);
        r.data.forward = q88_t'(f0);
        r.data.lateral = q88_t'(f1);
        r.data.heading = q88_t'(f2);
        r.typed        = typed;
        r.want         = want;
        directed.push_back(r);
    endtask

    task automatic random_phase(logic [LIMIT_W-1:0] sp, logic [LIMIT_W-1:0] tu);
        item_data_t d;
        int         pick;
        int         counted;
        wait_idle();
        set_limits(sp, tu);
        load_weights(1'b0);
        counted = 0;
        while (counted < PHASE_ITEMS) begin
            if (counted % 16 == 0) src_steady = ($urandom_range(0, 3) == 0);
            d    = rand_data();
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_item(MODE_EVAL, d, 1'b0, '0);
                counted++;
            end else if (pick < 90) begin
                send_item(MODE_WRITE, d, 1'b0, '0);
                counted++;
            end else begin
                d.windex = INDEX_W'($urandom_range(DEPTH, 2 ** INDEX_W - 1));
                send_item(MODE_WRITE, d, 1'b0, '0);
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_weights(1'b1);

        add_row(MODE_EVAL, 0, 0, 0, 0, 0, 1'b1, outs(0, 0, 0, 0));
        add_row(MODE_EVAL, 0, 0, 32767, -32768, 32767, 1'b1, outs(0, 0, 0, 0));
        add_row(MODE_WRITE, B2_BASE + 0, 32767, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, B2_BASE + 1, -32768, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, B2_BASE + 2, 32767, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, B2_BASE + 3, -32768, 0, 0, 0, 1'b0, '0);
        add_row(MODE_EVAL, 0, 0, 0, 0, 0, 1'b1,
                outs(SPEED_LIMIT_RESET, -int'(TURN_LIMIT_RESET), 32767, -32768));
        // writes past the end of the store
        add_row(MODE_WRITE, DEPTH, 16'h5a5a, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, 2 ** INDEX_W - 1, -1, 0, 0, 0, 1'b0, '0);
        add_row(MODE_EVAL, 0, 0, -1, 1, 256, 1'b1,
                outs(SPEED_LIMIT_RESET, -int'(TURN_LIMIT_RESET), 32767, -32768));
        add_row(MODE_WRITE, B2_BASE + 0, 128, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, B2_BASE + 1, -128, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, B2_BASE + 2, 0, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, B2_BASE + 3, 1, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, 0, 256, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, W2_BASE + 0, 256, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, W2_BASE + 1, -256, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, W2_BASE + 2, 128, 0, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, W2_BASE + 3, 32767, 0, 0, 0, 1'b0, '0);
        add_row(MODE_EVAL, 0, 0, 256, 0, 0, 1'b0, '0);
        add_row(MODE_EVAL, 0, 0, -256, 32767, -32768, 1'b0, '0);
        add_row(MODE_EVAL, 0, 0, 32767, 0, 0, 1'b0, '0);
        add_row(MODE_WRITE, B1_BASE + 0, -32768, 0, 0, 0, 1'b0, '0);
        add_row(MODE_EVAL, 0, 0, 32767, 0, 0, 1'b0, '0);
        add_row(MODE_EVAL, 0, 0, -32768, 0, 0, 1'b0, '0);
        foreach (directed[k]) begin
            send_item(directed[k].mode, directed[k].data, directed[k].typed, directed[k].want);
        end

        random_phase('0, '0);
        random_phase('1, '1);
        random_phase(LIMIT_W'($urandom), LIMIT_W'($urandom));
        random_phase(LIMIT_W'($urandom_range(0, 3072)), LIMIT_W'($urandom_range(0, 1024)));

        wait_idle();
        failures += pending.size();
        $display("stimulus: %0d weight words stored, %0d writes past the store, %0d evaluations",
                 writes, dropped, evals);
        $display("limits: reset, zero, full scale and two random settings; %0d results, %0d bad",
                 results_seen, failures);
        if (failures == 0) begin
            $display("mlp_policy_inference regression: pass");
        end else begin
            $display("mlp_policy_inference regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
hdl/mlpi_pkg.sv
hdl/mlpi_wmem.sv
hdl/mlpi_mac.sv
hdl/mlp_policy_inference.sv
tb/tb_mlp_policy_inference.sv
